### src/lsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the line segment clipper: region codes,
// configuration register indexes and sequencer states.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int unsigned CODE_W = 4;

    localparam logic [CODE_W-1:0] CODE_LEFT   = 4'b0001;
    localparam logic [CODE_W-1:0] CODE_RIGHT  = 4'b0010;
    localparam logic [CODE_W-1:0] CODE_BOTTOM = 4'b0100;
    localparam logic [CODE_W-1:0] CODE_TOP    = 4'b1000;

    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WINDOW_LEFT   = 2'd0,
        CFG_WINDOW_BOTTOM = 2'd1,
        CFG_WINDOW_RIGHT  = 2'd2,
        CFG_WINDOW_TOP    = 2'd3
    } cfg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_EVAL   = 8'b0000_0010,
        ST_SETUP  = 8'b0000_0100,
        ST_MULT   = 8'b0000_1000,
        ST_DSTART = 8'b0001_0000,
        ST_DWAIT  = 8'b0010_0000,
        ST_UPDATE = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

### src/line_segment_clipper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_segment_clipper_unit
// Cohen-Sutherland clipping of one line segment against a rectangular window.
// ----------------------------------------------------------------------------
// usage:
//   cfg channel writes the window (left, bottom, right, top); always ready,
//   to be used only while no segment is in flight
//   s channel takes one segment (two endpoints); s_ready is high only while
//   the sequencer is idle
//   m channel returns the accept flag and the clipped endpoints; a rejected
//   segment returns all coordinates as zero
// timing:
//   each clip step runs one multiply and one restoring division; a single
//   divider serves every step and works out one quotient bit per cycle
//   a segment takes n clip steps, n at most MAX_CLIP_STEPS; the block
//   accepts no new segment until its result is in the output register
//   a finished result sits in the output register; while m_ready is low the
//   block may take one more segment and holds its result until the slot frees
// reset:
//   aresetn clears the window to zero, drops m_valid and idles the sequencer
// ----------------------------------------------------------------------------
module line_segment_clipper_unit #(
    parameter int unsigned COORD_WIDTH    = 16,
    parameter int unsigned MAX_CLIP_STEPS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic signed [COORD_WIDTH-1:0]       cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [COORD_WIDTH-1:0]       s_start_x,
    input  logic signed [COORD_WIDTH-1:0]       s_start_y,
    input  logic signed [COORD_WIDTH-1:0]       s_end_x,
    input  logic signed [COORD_WIDTH-1:0]       s_end_y,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_accepted,
    output logic signed [COORD_WIDTH-1:0]       m_clipped_start_x,
    output logic signed [COORD_WIDTH-1:0]       m_clipped_start_y,
    output logic signed [COORD_WIDTH-1:0]       m_clipped_end_x,
    output logic signed [COORD_WIDTH-1:0]       m_clipped_end_y
);

    localparam int unsigned W      = COORD_WIDTH;
    localparam int unsigned STEP_W = $clog2(MAX_CLIP_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_CLIP_STEPS);
    localparam logic [2*W-1:0] QCAP = {{(W-1){1'b0}}, 1'b1, {W{1'b0}}};
    localparam logic signed [W+1:0] SAT_HI = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = {3'b111, {(W-1){1'b0}}};

    typedef logic signed [W-1:0] coord_t;
    typedef logic [lsc_pkg::CODE_W-1:0] code_t;

    // window registers
    coord_t win_left_reg, win_bottom_reg, win_right_reg, win_top_reg;

    // sequencer and datapath registers
    lsc_pkg::state_t state_reg, state_next;
    coord_t x1_reg, x1_next, y1_reg, y1_next, x2_reg, x2_next, y2_reg, y2_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic   acc_reg, acc_next;
    logic   side1_reg, side1_next;
    logic   clip_y_reg, clip_y_next;
    coord_t a1_reg, a1_next, b1_reg, b1_next, a2_reg, a2_next, b2_reg, b2_next;
    coord_t edge_reg, edge_next;
    logic [W-1:0] ua_reg, ua_next, un_reg, un_next, ud_reg, ud_next;
    logic   neg_reg, neg_next;
    logic [2*W-1:0] prod_reg, prod_next;

    // output registers
    logic   m_valid_reg, m_valid_next;
    logic   m_acc_reg, m_acc_next;
    coord_t m_sx_reg, m_sx_next, m_sy_reg, m_sy_next, m_ex_reg, m_ex_next;
    coord_t m_ey_reg, m_ey_next;

    logic               div_start;
    logic               div_done;
    logic [2*W-1:0]     div_quotient;

    code_t c1, c2, co;
    logic [2*W-1:0]     q_capped;
    logic signed [W+1:0] sum;
    coord_t             isect, nx, ny;

    function automatic code_t region(input coord_t x, input coord_t y,
                                     input coord_t wl, input coord_t wb,
                                     input coord_t wr, input coord_t wt);
        code_t c;
        c = '0;
        if (x < wl) begin
            c = c | lsc_pkg::CODE_LEFT;
        end else if (x > wr) begin
            c = c | lsc_pkg::CODE_RIGHT;
        end
        if (y < wb) begin
            c = c | lsc_pkg::CODE_BOTTOM;
        end else if (y > wt) begin
            c = c | lsc_pkg::CODE_TOP;
        end
        return c;
    endfunction

    function automatic logic [W-1:0] mag(input coord_t hi, input coord_t lo);
        logic signed [W:0] d;
        logic signed [W:0] n;
        d = {hi[W-1], hi} - {lo[W-1], lo};
        n = -d;
        return d[W] ? n[W-1:0] : d[W-1:0];
    endfunction

    function automatic logic sgn(input coord_t hi, input coord_t lo);
        logic signed [W:0] d;
        d = {hi[W-1], hi} - {lo[W-1], lo};
        return d[W];
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= '0;
            win_bottom_reg <= '0;
            win_right_reg  <= '0;
            win_top_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lsc_pkg::cfg_index_t'(cfg_index))
                lsc_pkg::CFG_WINDOW_LEFT:   win_left_reg   <= cfg_data;
                lsc_pkg::CFG_WINDOW_BOTTOM: win_bottom_reg <= cfg_data;
                lsc_pkg::CFG_WINDOW_RIGHT:  win_right_reg  <= cfg_data;
                lsc_pkg::CFG_WINDOW_TOP:    win_top_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign c1 = region(x1_reg, y1_reg, win_left_reg, win_bottom_reg,
                       win_right_reg, win_top_reg);
    assign c2 = region(x2_reg, y2_reg, win_left_reg, win_bottom_reg,
                       win_right_reg, win_top_reg);
    assign co = (c1 != '0) ? c1 : c2;

    // intersection finish: cap, apply sign, saturate
    assign q_capped = (div_quotient > QCAP) ? QCAP : div_quotient;
    assign sum = neg_reg ? ({{2{a1_reg[W-1]}}, a1_reg} - {1'b0, q_capped[W:0]})
                         : ({{2{a1_reg[W-1]}}, a1_reg} + {1'b0, q_capped[W:0]});
    always_comb begin
        if (sum > SAT_HI) begin
            isect = SAT_HI[W-1:0];
        end else if (sum < SAT_LO) begin
            isect = SAT_LO[W-1:0];
        end else begin
            isect = sum[W-1:0];
        end
        nx = clip_y_reg ? isect : edge_reg;
        ny = clip_y_reg ? edge_reg : isect;
    end

    assign s_ready   = (state_reg == lsc_pkg::ST_IDLE);
    assign div_start = (state_reg == lsc_pkg::ST_DSTART);

    always_comb begin
        state_next   = state_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        x2_next      = x2_reg;
        y2_next      = y2_reg;
        steps_next   = steps_reg;
        acc_next     = acc_reg;
        side1_next   = side1_reg;
        clip_y_next  = clip_y_reg;
        a1_next      = a1_reg;
        b1_next      = b1_reg;
        a2_next      = a2_reg;
        b2_next      = b2_reg;
        edge_next    = edge_reg;
        ua_next      = ua_reg;
        un_next      = un_reg;
        ud_next      = ud_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        m_valid_next = (m_valid_reg && m_ready) ? 1'b0 : m_valid_reg;
        m_acc_next   = m_acc_reg;
        m_sx_next    = m_sx_reg;
        m_sy_next    = m_sy_reg;
        m_ex_next    = m_ex_reg;
        m_ey_next    = m_ey_reg;

        unique case (state_reg)
            lsc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    x1_next    = s_start_x;
                    y1_next    = s_start_y;
                    x2_next    = s_end_x;
                    y2_next    = s_end_y;
                    steps_next = '0;
                    state_next = lsc_pkg::ST_EVAL;
                end
            end
            lsc_pkg::ST_EVAL: begin
                priority if (c1 == '0 && c2 == '0) begin
                    acc_next   = 1'b1;
                    state_next = lsc_pkg::ST_FINISH;
                end else if ((c1 & c2) != '0 || steps_reg >= STEP_MAX) begin
                    acc_next   = 1'b0;
                    state_next = lsc_pkg::ST_FINISH;
                end else begin
                    side1_next = (c1 != '0);
                    if ((co & (lsc_pkg::CODE_TOP | lsc_pkg::CODE_BOTTOM)) != '0) begin
                        clip_y_next = 1'b1;
                        a1_next     = x1_reg;
                        b1_next     = y1_reg;
                        a2_next     = x2_reg;
                        b2_next     = y2_reg;
                        edge_next   = ((co & lsc_pkg::CODE_TOP) != '0) ?
                                      win_top_reg : win_bottom_reg;
                    end else begin
                        clip_y_next = 1'b0;
                        a1_next     = y1_reg;
                        b1_next     = x1_reg;
                        a2_next     = y2_reg;
                        b2_next     = x2_reg;
                        edge_next   = ((co & lsc_pkg::CODE_RIGHT) != '0) ?
                                      win_right_reg : win_left_reg;
                    end
                    state_next = lsc_pkg::ST_SETUP;
                end
            end
            lsc_pkg::ST_SETUP: begin
                ua_next    = mag(a2_reg, a1_reg);
                un_next    = mag(edge_reg, b1_reg);
                ud_next    = mag(b2_reg, b1_reg);
                neg_next   = sgn(a2_reg, a1_reg) ^ sgn(edge_reg, b1_reg)
                             ^ sgn(b2_reg, b1_reg);
                state_next = lsc_pkg::ST_MULT;
            end
            lsc_pkg::ST_MULT: begin
                prod_next  = ua_reg * un_reg;
                state_next = lsc_pkg::ST_DSTART;
            end
            lsc_pkg::ST_DSTART: begin
                state_next = lsc_pkg::ST_DWAIT;
            end
            lsc_pkg::ST_DWAIT: begin
                if (div_done) begin
                    state_next = lsc_pkg::ST_UPDATE;
                end
            end
            lsc_pkg::ST_UPDATE: begin
                if (side1_reg) begin
                    x1_next = nx;
                    y1_next = ny;
                end else begin
                    x2_next = nx;
                    y2_next = ny;
                end
                steps_next = steps_reg + 1'b1;
                state_next = lsc_pkg::ST_EVAL;
            end
            lsc_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_acc_next   = acc_reg;
                    m_sx_next    = acc_reg ? x1_reg : '0;
                    m_sy_next    = acc_reg ? y1_reg : '0;
                    m_ex_next    = acc_reg ? x2_reg : '0;
                    m_ey_next    = acc_reg ? y2_reg : '0;
                    state_next   = lsc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsc_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            steps_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            steps_reg   <= steps_next;
        end
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        acc_reg    <= acc_next;
        side1_reg  <= side1_next;
        clip_y_reg <= clip_y_next;
        a1_reg     <= a1_next;
        b1_reg     <= b1_next;
        a2_reg     <= a2_next;
        b2_reg     <= b2_next;
        edge_reg   <= edge_next;
        ua_reg     <= ua_next;
        un_reg     <= un_next;
        ud_reg     <= ud_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        m_acc_reg  <= m_acc_next;
        m_sx_reg   <= m_sx_next;
        m_sy_reg   <= m_sy_next;
        m_ex_reg   <= m_ex_next;
        m_ey_reg   <= m_ey_next;
    end

    lsc_divider #(
        .DIVIDEND_W (2 * W),
        .DIVISOR_W  (W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (ud_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid           = m_valid_reg;
    assign m_accepted        = m_acc_reg;
    assign m_clipped_start_x = m_sx_reg;
    assign m_clipped_start_y = m_sy_reg;
    assign m_clipped_end_x   = m_ex_reg;
    assign m_clipped_end_y   = m_ey_reg;

    // rejected results carry zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_accepted) |-> (m_clipped_start_x == '0 && m_clipped_start_y == '0
            && m_clipped_end_x == '0 && m_clipped_end_y == '0))
        else $error("rejected result with nonzero coordinates");

    // accepted endpoints lie inside the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |->
            (m_clipped_start_x >= win_left_reg && m_clipped_start_x <= win_right_reg
            && m_clipped_start_y >= win_bottom_reg && m_clipped_start_y <= win_top_reg
            && m_clipped_end_x >= win_left_reg && m_clipped_end_x <= win_right_reg
            && m_clipped_end_y >= win_bottom_reg && m_clipped_end_y <= win_top_reg))
        else $error("accepted endpoint outside the window");

    // divider completes only while the sequencer waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == lsc_pkg::ST_DWAIT))
        else $error("divider done outside wait state");

    // step count never passes the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        steps_reg <= STEP_MAX)
        else $error("clip step count past cap");

    // an input transfer starts evaluation on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == lsc_pkg::ST_EVAL && steps_reg == '0))
        else $error("input transfer did not start evaluation");

endmodule

### src/lsc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_divider
// Unsigned restoring divider, one quotient bit per cycle. A zero divisor
// gives a zero quotient.
// ----------------------------------------------------------------------------
module lsc_divider #(
    parameter int unsigned DIVIDEND_W = 32,
    parameter int unsigned DIVISOR_W  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff       = trial - {1'b0, dvs_reg};
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            count_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_COUNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (dvs_reg == '0) ? '0 : quo_reg;

endmodule

### bench/tb_line_segment_clipper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_clipper_unit
// Self-checking bench for the segment clipper. A directed table of segments
// runs over a few fixed windows: reset, ordinary, full range, inverted and
// one-pixel-wide; typed rows carry their result. Random windows, segments
// and stalls on both channels follow; a bench clipper checks the rest.
// ----------------------------------------------------------------------------
module tb_line_segment_clipper_unit;

    localparam int CW = 16;
    localparam int MAX_STEPS = 8;
    localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;
    localparam int PHASE_ITEMS = 72;
    localparam int QUIET_PHASE = 5;
    localparam int TAIL_CYCLES = 320;

    typedef struct {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } segment_t;

    typedef struct {
        logic                 accepted;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } clip_result_t;

    // window, segment, typed flag, typed result
    typedef struct {
        int wl, wb, wr, wt;
        int sx, sy, ex, ey;
        bit typed;
        bit acc;
        int csx, csy, cex, cey;
    } clip_case_t;

    typedef enum {WIN_NORMAL, WIN_INVERTED, WIN_LINE, WIN_ANY, WIN_FULL} win_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    lsc_pkg::cfg_index_t  cfg_index;
    logic signed [CW-1:0] cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CW-1:0] s_start_x;
    logic signed [CW-1:0] s_start_y;
    logic signed [CW-1:0] s_end_x;
    logic signed [CW-1:0] s_end_y;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_accepted;
    logic signed [CW-1:0] m_clipped_start_x;
    logic signed [CW-1:0] m_clipped_start_y;
    logic signed [CW-1:0] m_clipped_end_x;
    logic signed [CW-1:0] m_clipped_end_y;

    logic signed [CW-1:0] win_left;
    logic signed [CW-1:0] win_bottom;
    logic signed [CW-1:0] win_right;
    logic signed [CW-1:0] win_top;

    clip_result_t pending_clips[$];
    int           error_count;
    bit           no_idle;

    clip_case_t directed_cases [23] = '{
        '{0, 0, 0, 0,  0, 0, 0, 0,  1'b1, 1'b1,  0, 0, 0, 0},
        '{0, 0, 0, 0,  1, 1, 2, 2,  1'b1, 1'b0,  0, 0, 0, 0},
        '{0, 0, 0, 0,  -32768, -32768, -32768, 32767,  1'b1, 1'b0,  0, 0, 0, 0},
        '{0, 0, 0, 0,  32767, -5, 32767, 5,  1'b1, 1'b0,  0, 0, 0, 0},
        '{0, 0, 0, 0,  -32768, -32768, 32767, 32767,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  -20, 10, 30, -40,  1'b1, 1'b1,  -20, 10, 30, -40},
        '{-100, -50, 100, 50,  -100, -50, 100, 50,  1'b1, 1'b1,  -100, -50, 100, 50},
        '{-100, -50, 100, 50,  0, 0, 0, 200,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  0, 0, 0, -200,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  0, 0, 300, 10,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  -300, -10, 0, 0,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  -300, -200, 300, 200,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  -150, 40, -90, 100,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  200, 0, 200, 10,  1'b1, 1'b0,  0, 0, 0, 0},
        '{-100, -50, 100, 50,  -32768, 32767, 32767, -32768,  1'b0, 1'b0,  0, 0, 0, 0},
        '{-32768, -32768, 32767, 32767,  -32768, -32768, 32767, 32767,
          1'b1, 1'b1,  -32768, -32768, 32767, 32767},
        '{-32768, -32768, 32767, 32767,  32767, -32768, -32768, 32767,
          1'b1, 1'b1,  32767, -32768, -32768, 32767},
        '{100, 50, -100, -50,  0, 0, 10, 10,  1'b0, 1'b0,  0, 0, 0, 0},
        '{100, 50, -100, -50,  -32768, -32768, 32767, 32767,  1'b0, 1'b0,  0, 0, 0, 0},
        '{100, 50, -100, -50,  200, -200, -200, 200,  1'b0, 1'b0,  0, 0, 0, 0},
        '{32767, 32767, -32768, -32768,  -32768, 0, 32767, 5,  1'b0, 1'b0,  0, 0, 0, 0},
        '{32767, 32767, -32768, -32768,  0, -32768, 5, 32767,  1'b0, 1'b0,  0, 0, 0, 0},
        '{0, -32768, 0, 32767,  -10, -10, 10, 10,  1'b0, 1'b0,  0, 0, 0, 0}
    };

    win_mode_t phase_plan [7] = '{WIN_NORMAL, WIN_INVERTED, WIN_LINE, WIN_ANY,
                                  WIN_FULL, WIN_NORMAL, WIN_NORMAL};

    line_segment_clipper_unit #(
        .COORD_WIDTH    (CW),
        .MAX_CLIP_STEPS (MAX_STEPS)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_x         (s_start_x),
        .s_start_y         (s_start_y),
        .s_end_x           (s_end_x),
        .s_end_y           (s_end_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_clipped_start_x (m_clipped_start_x),
        .m_clipped_start_y (m_clipped_start_y),
        .m_clipped_end_x   (m_clipped_end_x),
        .m_clipped_end_y   (m_clipped_end_y)
    );

    function automatic longint sat_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    function automatic logic [lsc_pkg::CODE_W-1:0] region_of(longint x, longint y);
        logic [lsc_pkg::CODE_W-1:0] c;
        c = '0;
        if (x < win_left) c |= lsc_pkg::CODE_LEFT;
        else if (x > win_right) c |= lsc_pkg::CODE_RIGHT;
        if (y < win_bottom) c |= lsc_pkg::CODE_BOTTOM;
        else if (y > win_top) c |= lsc_pkg::CODE_TOP;
        return c;
    endfunction

    // a1 + (a2-a1)*(edge_pos-b1)/(b2-b1), quotient truncated toward zero
    function automatic longint edge_cross(longint a1, longint b1, longint a2, longint b2,
                                          longint edge_pos);
        longint da, dn, dd, q;
        bit     neg;
        da  = a2 - a1;
        dn  = edge_pos - b1;
        dd  = b2 - b1;
        neg = 1'b0;
        if (da < 0) begin da = -da; neg = !neg; end
        if (dn < 0) begin dn = -dn; neg = !neg; end
        if (dd < 0) begin dd = -dd; neg = !neg; end
        q = (dd == 0) ? 0 : (da * dn) / dd;
        if (q > (longint'(1) << CW)) q = longint'(1) << CW;
        return sat_coord(neg ? a1 - q : a1 + q);
    endfunction

    function automatic clip_result_t clip_segment(segment_t seg);
        longint                     x1, y1, x2, y2, nx, ny;
        logic [lsc_pkg::CODE_W-1:0] c1, c2, co;
        int                         step;
        bit                         acc;
        clip_result_t               r;
        x1   = seg.start_x;
        y1   = seg.start_y;
        x2   = seg.end_x;
        y2   = seg.end_y;
        c1   = region_of(x1, y1);
        c2   = region_of(x2, y2);
        acc  = 1'b0;
        step = 0;
        while (1'b1) begin
            if (c1 == '0 && c2 == '0) begin
                acc = 1'b1;
                break;
            end
            if ((c1 & c2) != '0) break;
            if (step >= MAX_STEPS) break;
            co = (c1 != '0) ? c1 : c2;
            if ((co & lsc_pkg::CODE_TOP) != '0) begin
                nx = edge_cross(x1, y1, x2, y2, win_top);
                ny = win_top;
            end else if ((co & lsc_pkg::CODE_BOTTOM) != '0) begin
                nx = edge_cross(x1, y1, x2, y2, win_bottom);
                ny = win_bottom;
            end else if ((co & lsc_pkg::CODE_RIGHT) != '0) begin
                ny = edge_cross(y1, x1, y2, x2, win_right);
                nx = win_right;
            end else begin
                ny = edge_cross(y1, x1, y2, x2, win_left);
                nx = win_left;
            end
            if (c1 != '0) begin
                x1 = nx; y1 = ny; c1 = region_of(x1, y1);
            end else begin
                x2 = nx; y2 = ny; c2 = region_of(x2, y2);
            end
            step++;
        end
        r.accepted = acc;
        r.start_x  = acc ? x1[CW-1:0] : '0;
        r.start_y  = acc ? y1[CW-1:0] : '0;
        r.end_x    = acc ? x2[CW-1:0] : '0;
        r.end_y    = acc ? y2[CW-1:0] : '0;
        return r;
    endfunction

    function automatic logic signed [CW-1:0] coord_near(int lo, int hi);
        int a, b, s, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        s = b - a + 16;
        v = a - s + int'($urandom_range(3 * s));
        v = int'(sat_coord(v));
        return v[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] pick_coord(int lo, int hi);
        int sel, v;
        sel = int'($urandom_range(99));
        if (sel < 60) return coord_near(lo, hi);
        if (sel < 90) return CW'($urandom_range(65535));
        case ($urandom_range(3))
            0: v = int'(COORD_MIN);
            1: v = int'(COORD_MAX);
            2: v = lo;
            default: v = hi;
        endcase
        return v[CW-1:0];
    endfunction

    task automatic pick_window(win_mode_t mode, output int l, output int b,
                               output int r, output int t);
        int tmp;
        l = int'($urandom_range(40000)) - 20000;
        r = l + int'($urandom_range(8000));
        b = int'($urandom_range(40000)) - 20000;
        t = b + int'($urandom_range(8000));
        case (mode)
            WIN_INVERTED: begin
                tmp = l; l = r; r = tmp;
                tmp = b; b = t; t = tmp;
            end
            WIN_LINE: begin
                if ($urandom_range(1) == 0) r = l;
                else t = b;
            end
            WIN_ANY: begin
                l = int'($urandom_range(65535)) - 32768;
                b = int'($urandom_range(65535)) - 32768;
                r = int'($urandom_range(65535)) - 32768;
                t = int'($urandom_range(65535)) - 32768;
            end
            WIN_FULL: begin
                l = int'(COORD_MIN); b = int'(COORD_MIN);
                r = int'(COORD_MAX); t = int'(COORD_MAX);
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    task automatic drain_pending();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_clips.size() == 0);
    endtask

    task automatic write_reg(lsc_pkg::cfg_index_t idx, logic signed [CW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            lsc_pkg::CFG_WINDOW_LEFT:   win_left   = val;
            lsc_pkg::CFG_WINDOW_BOTTOM: win_bottom = val;
            lsc_pkg::CFG_WINDOW_RIGHT:  win_right  = val;
            lsc_pkg::CFG_WINDOW_TOP:    win_top    = val;
            default: ;
        endcase
    endtask

    task automatic apply_window(int l, int b, int r, int t);
        drain_pending();
        write_reg(lsc_pkg::CFG_WINDOW_LEFT, l[CW-1:0]);
        write_reg(lsc_pkg::CFG_WINDOW_BOTTOM, b[CW-1:0]);
        write_reg(lsc_pkg::CFG_WINDOW_RIGHT, r[CW-1:0]);
        write_reg(lsc_pkg::CFG_WINDOW_TOP, t[CW-1:0]);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_segment(segment_t seg, clip_result_t want);
        @(negedge aclk);
        if (!no_idle && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_start_x <= seg.start_x;
        s_start_y <= seg.start_y;
        s_end_x   <= seg.end_x;
        s_end_y   <= seg.end_y;
        do @(posedge aclk); while (!s_ready);
        pending_clips.push_back(want);
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= no_idle || ($urandom_range(99) >= 10);
        end
    end

    // result checker
    always @(posedge aclk) begin
        clip_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_clips.size() == 0) begin
                $display("%0t ns: result transfer with nothing pending", $time);
                error_count++;
            end else begin
                want = pending_clips.pop_front();
                check_field("accepted", want.accepted, m_accepted);
                check_field("clipped_start_x", want.start_x, m_clipped_start_x);
                check_field("clipped_start_y", want.start_y, m_clipped_start_y);
                check_field("clipped_end_x", want.end_x, m_clipped_end_x);
                check_field("clipped_end_y", want.end_y, m_clipped_end_y);
            end
        end
    end

    initial begin
        #(2_000_000);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        clip_case_t   row;
        segment_t     seg;
        clip_result_t want;
        int           i, p, n, l, b, r, t;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = lsc_pkg::CFG_WINDOW_LEFT;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_start_x   = '0;
        s_start_y   = '0;
        s_end_x     = '0;
        s_end_y     = '0;
        win_left    = '0;
        win_bottom  = '0;
        win_right   = '0;
        win_top     = '0;
        error_count = 0;
        no_idle     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < $size(directed_cases); i++) begin
            row = directed_cases[i];
            if (row.wl != win_left || row.wb != win_bottom ||
                row.wr != win_right || row.wt != win_top) begin
                apply_window(row.wl, row.wb, row.wr, row.wt);
            end
            seg.start_x = row.sx[CW-1:0];
            seg.start_y = row.sy[CW-1:0];
            seg.end_x   = row.ex[CW-1:0];
            seg.end_y   = row.ey[CW-1:0];
            if (row.typed) begin
                want.accepted = row.acc;
                want.start_x  = row.csx[CW-1:0];
                want.start_y  = row.csy[CW-1:0];
                want.end_x    = row.cex[CW-1:0];
                want.end_y    = row.cey[CW-1:0];
            end else begin
                want = clip_segment(seg);
            end
            send_segment(seg, want);
        end

        for (p = 0; p < $size(phase_plan); p++) begin
            pick_window(phase_plan[p], l, b, r, t);
            apply_window(l, b, r, t);
            no_idle = (p == QUIET_PHASE);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender until the block has emptied out
                if (p == 0 && n == PHASE_ITEMS / 2) drain_pending();
                seg.start_x = pick_coord(win_left, win_right);
                seg.start_y = pick_coord(win_bottom, win_top);
                seg.end_x   = pick_coord(win_left, win_right);
                seg.end_y   = pick_coord(win_bottom, win_top);
                send_segment(seg, clip_segment(seg));
            end
        end

        drain_pending();
        // longest clip plus margin, to catch stray results
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### line_segment_clipper_unit.f
src/lsc_pkg.sv
src/lsc_divider.sv
src/line_segment_clipper_unit.sv
bench/tb_line_segment_clipper_unit.sv
